>>> sv/lfrp_pkg.sv
// shared types, constants and helper functions for the led fade ramp block
`default_nettype none

package lfrp_pkg;

    // operation codes carried in the input beat
    localparam logic [2:0] OP_TICK        = 3'd0;
    localparam logic [2:0] OP_TURN_ON     = 3'd1;
    localparam logic [2:0] OP_TURN_OFF    = 3'd2;
    localparam logic [2:0] OP_SET_LEVEL   = 3'd3;
    localparam logic [2:0] OP_CHANGE_TIME = 3'd4;

    // configuration register indexes
    localparam logic [0:0] REG_UPDATE_INTERVAL  = 1'b0;
    localparam logic [0:0] REG_ORIENTATION_DOWN = 1'b1;

    localparam int TIME_W     = 32;
    localparam int LVL_W      = 12;
    localparam int DIFF_W     = 13;
    localparam int PROD_W     = 45;
    localparam int QUO_W      = 44;
    localparam int SUM_W      = 46;
    localparam int MAX_WRITES = 64;
    localparam int CNT_W      = 6;

    localparam logic [15:0] UPDATE_INTERVAL_RESET = 16'd20;
    localparam logic [9:0]  LEVEL_MAX  = 10'd1023;
    localparam logic [11:0] LEVEL_TOP  = 12'd1023;
    localparam logic [9:0]  SAT_KNEE   = 10'd426;
    localparam logic [12:0] SAT_LIMIT  = 13'd5115;
    localparam logic [16:0] SAT_ROUND  = 17'd1022;
    localparam logic [7:0]  SAT_BASE   = 8'd170;
    localparam logic [18:0] BRI_LIMIT  = 19'd5115;
    localparam logic [17:0] BRI_MULT   = 18'd51;
    localparam logic [7:0]  BRI_FULL   = 8'd255;

    // commands from the controller to the datapath
    typedef struct packed {
        logic setup;
        logic prep;
        logic mul;
        logic div_start;
        logic finish;
        logic emit;
    } lfrp_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic tick_due;
        logic div_done;
        logic emit_ok;
        logic emit_last;
    } lfrp_status_t;

    // floor(x / 1023) for x below 2^18: x >> 10 is at most one short,
    // the leftover stays under twice 1023 so one correction is enough
    function automatic logic [7:0] div1023(input logic [17:0] x);
        logic [7:0]  q0;
        logic [10:0] r;
        q0 = x[17:10];
        r  = 11'(x[9:0]) + 11'(q0);
        return (r >= 11'd1023) ? (q0 + 8'd1) : q0;
    endfunction

endpackage

`default_nettype wire

>>> sv/lfrp_div.sv
// restoring unsigned divider, one quotient bit per cycle
`default_nettype none

module lfrp_div import lfrp_pkg::*; #(
    parameter int DW = 44,
    parameter int VW = 32
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          start,
    input  wire logic [DW-1:0] dividend,
    input  wire logic [VW-1:0] divisor,
    output logic               done,
    output logic [DW-1:0]      quotient
);

    localparam int CW = $clog2(DW + 1);

    logic [DW-1:0] dq_reg, dq_next;
    logic [VW-1:0] rem_reg, rem_next;
    logic [VW-1:0] dvs_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;
    logic [VW:0]   shifted;
    logic          ge;

    always_comb begin
        shifted  = {rem_reg, dq_reg[DW-1]};
        ge       = shifted >= {1'b0, dvs_reg};
        rem_next = ge ? VW'(shifted - {1'b0, dvs_reg}) : shifted[VW-1:0];
        dq_next  = {dq_reg[DW-2:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(DW);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            dq_reg  <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            dq_reg  <= dq_next;
            rem_reg <= rem_next;
        end
    end

    assign done     = done_reg;
    assign quotient = dq_reg;

endmodule

`default_nettype wire

>>> sv/lfrp_ctrl.sv
// controller state machine sequencing set-up, interpolation and led writes
`default_nettype none

module lfrp_ctrl import lfrp_pkg::*; (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire lfrp_status_t status,
    output lfrp_cmd_t         cmd
);

    typedef enum logic [6:0] {
        ST_IDLE      = 7'b0000001,
        ST_PREP      = 7'b0000010,
        ST_MUL       = 7'b0000100,
        ST_DIV_START = 7'b0001000,
        ST_DIV_WAIT  = 7'b0010000,
        ST_FINISH    = 7'b0100000,
        ST_EMIT      = 7'b1000000
    } lfrp_state_t;

    lfrp_state_t state_reg, state_next;
    logic        accept;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        state_next    = state_reg;
        cmd           = '0;
        cmd.setup     = accept;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept && status.tick_due) state_next = ST_PREP;
            end
            ST_PREP: begin
                cmd.prep   = 1'b1;
                state_next = ST_MUL;
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = ST_DIV_START;
            end
            ST_DIV_START: begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (status.div_done) state_next = ST_FINISH;
            end
            ST_FINISH: begin
                cmd.finish = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                cmd.emit = status.emit_ok;
                if (status.emit_ok && status.emit_last) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

>>> sv/lfrp_dp.sv
// datapath: ramp state, interpolation, profile math and output stage
`default_nettype none

module lfrp_dp import lfrp_pkg::*; #(
    parameter int SIDES         = 4,
    parameter int LEDS_PER_SIDE = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [0:0]  cfg_index,
    input  wire logic [15:0] cfg_wdata,
    input  wire logic [2:0]  s_operation,
    input  wire logic [31:0] s_now_ms,
    input  wire logic [15:0] s_duration,
    input  wire logic [9:0]  s_target_level,
    input  wire lfrp_cmd_t   cmd,
    output lfrp_status_t     status,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic             m_tlast,
    output logic [39:0]      m_tdata
);

    localparam int TOTAL_RAW = SIDES * LEDS_PER_SIDE;
    localparam int TOTAL     = (TOTAL_RAW > MAX_WRITES) ? MAX_WRITES : TOTAL_RAW;
    localparam int PW        = (LEDS_PER_SIDE > 1) ? $clog2(LEDS_PER_SIDE + 1) : 1;
    localparam int SW        = (SIDES > 1) ? $clog2(SIDES) : 1;

    // configuration and ramp state
    logic [15:0]              upd_int_reg;
    logic                     orient_reg;
    logic signed [LVL_W-1:0]  level_reg;
    logic signed [LVL_W-1:0]  start_lvl_reg;
    logic signed [LVL_W-1:0]  end_lvl_reg;
    logic [TIME_W-1:0]        start_time_reg;
    logic [TIME_W-1:0]        end_time_reg;
    logic [TIME_W-1:0]        last_upd_reg;

    // per tick working registers
    logic [TIME_W-1:0]        now_reg;
    logic signed [TIME_W-1:0] num_reg;
    logic signed [TIME_W-1:0] den_reg;
    logic signed [DIFF_W-1:0] diff_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic                     neg_reg;
    logic                     den_zero_reg;

    // write sequencing
    logic [PW-1:0]    pos_reg;
    logic [SW-1:0]    side_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [18:0]      p_reg;

    // output stage
    logic        m_valid_reg;
    logic        m_last_reg;
    logic [39:0] m_data_reg;

    // set-up arithmetic
    logic [TIME_W-1:0]       dur_ext;
    logic [TIME_W-1:0]       ramp_end_new;
    logic [TIME_W-1:0]       end_moved;
    logic signed [LVL_W-1:0] level_inc;
    logic signed [LVL_W-1:0] level_dec;

    // interpolation
    logic [TIME_W-1:0]        t_clamped;
    logic [QUO_W-1:0]         prod_mag;
    logic [TIME_W-1:0]        den_mag;
    logic                     div_done;
    logic [QUO_W-1:0]         quotient;
    logic signed [SUM_W-1:0]  q_signed;
    logic signed [SUM_W-1:0]  lvl_sum;
    logic [9:0]               lvl_clamped;

    // profile
    logic [9:0]  level_cur;
    logic [12:0] step;
    logic [18:0] p_cur;
    logic [7:0]  bri;
    logic [12:0] sat_a;
    logic [16:0] sat_x;
    logic [7:0]  sat;
    logic        anim;
    logic        up;
    logic [PW-1:0] posn;
    logic [9:0]  idx_full;
    logic        last_beat;

    assign dur_ext      = {{16{s_duration[15]}}, s_duration};
    assign ramp_end_new = s_now_ms + dur_ext;
    assign end_moved    = end_time_reg + dur_ext;
    assign level_inc    = level_reg + 12'sd1;
    assign level_dec    = level_reg - 12'sd1;

    assign status.tick_due  = (s_operation == OP_TICK) &&
                              ((s_now_ms - last_upd_reg) > {16'd0, upd_int_reg});
    assign status.div_done  = div_done;
    assign status.emit_ok   = !m_valid_reg || m_tready;
    assign status.emit_last = last_beat;

    // time clamp to the ramp window, unsigned compares
    always_comb begin
        if (now_reg < start_time_reg) begin
            t_clamped = start_time_reg;
        end else if (now_reg > end_time_reg) begin
            t_clamped = end_time_reg;
        end else begin
            t_clamped = now_reg;
        end
    end

    // product magnitude stays below 2^43
    assign prod_mag = prod_reg[PROD_W-1] ? QUO_W'(-prod_reg) : QUO_W'(prod_reg);
    assign den_mag  = den_reg[TIME_W-1] ? TIME_W'(-den_reg) : TIME_W'(den_reg);

    lfrp_div #(
        .DW (QUO_W),
        .VW (TIME_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (prod_mag),
        .divisor  (den_mag),
        .done     (div_done),
        .quotient (quotient)
    );

    // signed quotient plus start level, truncated toward zero, then clamp; a zero span gives the end level
    always_comb begin
        q_signed = $signed({2'b00, quotient});
        if (neg_reg) q_signed = -q_signed;
        if (den_zero_reg) begin
            lvl_sum = SUM_W'(end_lvl_reg);
        end else begin
            lvl_sum = q_signed + SUM_W'(start_lvl_reg);
        end
        if (lvl_sum < 0) begin
            lvl_clamped = '0;
        end else if (lvl_sum > $signed(SUM_W'(LEVEL_MAX))) begin
            lvl_clamped = LEVEL_MAX;
        end else begin
            lvl_clamped = lvl_sum[9:0];
        end
    end

    // per led profile from the frame level
    always_comb begin
        level_cur = level_reg[9:0];
        step      = 13'({level_cur, 3'b000}) - 13'(level_cur);
        p_cur     = p_reg + 19'(step);
        if (p_cur >= BRI_LIMIT) begin
            bri = BRI_FULL;
        end else begin
            bri = div1023(18'(p_cur[12:0]) * BRI_MULT);
        end
        sat_a = (level_cur > SAT_KNEE) ? SAT_LIMIT : 13'(level_cur) * 13'd12;
        sat_x = {sat_a, 4'b0000} + SAT_ROUND;
        sat   = SAT_BASE - div1023(18'(sat_x));
        anim  = (level_reg != end_lvl_reg);
        up    = side_reg[0] ^ orient_reg;
        posn  = up ? pos_reg : (PW'(LEDS_PER_SIDE - 1) - pos_reg);
        idx_full  = 10'(side_reg) * 10'(LEDS_PER_SIDE) + 10'(posn);
        last_beat = (cnt_reg == CNT_W'(TOTAL - 1));
    end

    // configuration and ramp state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upd_int_reg    <= UPDATE_INTERVAL_RESET;
            orient_reg     <= 1'b0;
            level_reg      <= '0;
            start_lvl_reg  <= '0;
            end_lvl_reg    <= '0;
            start_time_reg <= '0;
            end_time_reg   <= '0;
            last_upd_reg   <= '0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    REG_UPDATE_INTERVAL:  upd_int_reg <= cfg_wdata;
                    REG_ORIENTATION_DOWN: orient_reg  <= cfg_wdata[0];
                    default: ;
                endcase
            end
            if (cmd.setup) begin
                unique case (s_operation)
                    OP_TURN_ON: begin
                        start_lvl_reg  <= level_inc;
                        end_lvl_reg    <= $signed(LEVEL_TOP);
                        level_reg      <= level_inc;
                        start_time_reg <= s_now_ms;
                        end_time_reg   <= ramp_end_new;
                    end
                    OP_TURN_OFF: begin
                        start_lvl_reg  <= level_dec;
                        end_lvl_reg    <= '0;
                        level_reg      <= level_dec;
                        start_time_reg <= s_now_ms;
                        end_time_reg   <= ramp_end_new;
                    end
                    OP_SET_LEVEL: begin
                        start_lvl_reg  <= level_reg;
                        end_lvl_reg    <= $signed({2'b00, s_target_level});
                        start_time_reg <= s_now_ms;
                        end_time_reg   <= ramp_end_new;
                    end
                    OP_CHANGE_TIME: begin
                        if (end_moved > s_now_ms) end_time_reg <= end_moved;
                    end
                    default: ;
                endcase
            end
            if (cmd.finish) begin
                level_reg    <= $signed({2'b00, lvl_clamped});
                last_upd_reg <= now_reg;
            end
        end
    end

    // working registers of one tick
    always_ff @(posedge aclk) begin
        if (cmd.setup) now_reg <= s_now_ms;
        if (cmd.prep) begin
            num_reg      <= $signed(t_clamped - start_time_reg);
            den_reg      <= $signed(end_time_reg - start_time_reg);
            diff_reg     <= DIFF_W'(end_lvl_reg) - DIFF_W'(start_lvl_reg);
        end
        if (cmd.mul) begin
            prod_reg     <= num_reg * diff_reg;
            den_zero_reg <= (den_reg == '0);
        end
        if (cmd.div_start) neg_reg <= prod_reg[PROD_W-1] ^ den_reg[TIME_W-1];
    end

    // write counters, pos outer and side inner
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            side_reg <= '0;
            pos_reg  <= '0;
            p_reg    <= '0;
        end else if (cmd.finish) begin
            cnt_reg  <= '0;
            side_reg <= '0;
            pos_reg  <= '0;
            p_reg    <= '0;
        end else if (cmd.emit) begin
            cnt_reg <= cnt_reg + 1'b1;
            if (side_reg == SW'(SIDES - 1)) begin
                side_reg <= '0;
                pos_reg  <= pos_reg + 1'b1;
                p_reg    <= p_cur;
            end else begin
                side_reg <= side_reg + 1'b1;
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_data_reg <= {7'd0, anim, level_cur, bri, sat, idx_full[5:0]};
            m_last_reg <= last_beat;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = m_data_reg;

endmodule

`default_nettype wire

>>> sv/led_fade_ramp_profile.sv
// top level of the led fade ramp with per-position hsv profile
//
// input stream: one beat per operation. s_tuser carries the operation
// (tick, turn on, turn off, set level, change time), s_tdata the time,
// duration and target level. set-up beats and ticks that are not yet due
// are taken without leaving the idle state and produce nothing.
// a due tick runs the ramp interpolation: clamp and subtract, a 32x13
// signed multiply, divider load, a restoring divider that retires one
// quotient bit per cycle and flags done, then level update. then the
// first led write is loaded into the output register and one write per
// cycle follows unless the output stalls, min(SIDES*LEDS_PER_SIDE, 64)
// writes in all; the last carries m_tlast.
// s_tready is low while a tick is being worked on and high otherwise.
// m_tvalid/m_tready stalls just hold the writer; the frame resumes as
// soon as the receiver takes the waiting beat. the next input beat can be
// taken while the final write of a frame still waits at the output.
// reset (aresetn low, synchronous) clears the ramp state and times,
// sets update_interval to 20 ms and orientation to normal.
`default_nettype none

module led_fade_ramp_profile import lfrp_pkg::*; #(
    parameter int SIDES         = 4,
    parameter int LEDS_PER_SIDE = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    // configuration: index 0 update_interval, index 1 orientation_down
    input  wire logic        cfg_wr_en,
    input  wire logic [0:0]  cfg_index,
    input  wire logic [15:0] cfg_wdata,

    // input beats
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,   // now_ms[31:0], duration[47:32], target_level[57:48]
    input  wire logic [2:0]  s_tuser,   // operation[2:0]

    // led writes
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,   // led_index[5:0], saturation[13:6], brightness[21:14],
                                        // current_level[31:22], animating[32]
    output logic             m_tlast    // last_write
);

    localparam int TOTAL_RAW = SIDES * LEDS_PER_SIDE;
    localparam int TOTAL     = (TOTAL_RAW > MAX_WRITES) ? MAX_WRITES : TOTAL_RAW;

    lfrp_cmd_t    cmd;
    lfrp_status_t status;

    // sequencing of one beat: accept, interpolate, write out
    lfrp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // ramp state, arithmetic and output register
    lfrp_dp #(
        .SIDES         (SIDES),
        .LEDS_PER_SIDE (LEDS_PER_SIDE)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_operation    (s_tuser),
        .s_now_ms       (s_tdata[31:0]),
        .s_duration     (s_tdata[47:32]),
        .s_target_level (s_tdata[57:48]),
        .cmd            (cmd),
        .status         (status),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tlast        (m_tlast),
        .m_tdata        (m_tdata)
    );

    // a due tick closes the input until its frame is written
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && status.tick_due) |=> !s_tready)
        else $error("input still open after a due tick");

    // a write is only loaded when the output register can take it
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> (!m_tvalid || m_tready))
        else $error("led write overran the output register");

    // every written position lies on the strip
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (int'(m_tdata[5:0]) < TOTAL))
        else $error("led index beyond strip length");

endmodule

`default_nettype wire

>>> bench/led_fade_ramp_profile_tb.sv
// self-checking bench for the led fade ramp: predicts every led write of a frame and compares it
module led_fade_ramp_profile_tb import lfrp_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SIDES         = 4;
    localparam int LEDS_PER_SIDE = 16;

    // operation codes the block has no use for
    localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
    localparam logic [2:0] OP_SPARE_LAST  = 3'd7;

    localparam int GAP_PCT       = 11;   // chance per cycle that a side idles
    localparam int REPORT_LIMIT  = 10;
    localparam int SETTLE_CYCLES = 150;  // longer than one due tick takes inside the block

    // one led write as it leaves the block
    typedef struct packed {
        logic [5:0] led_idx;
        logic [7:0] sat;
        logic [7:0] bri;
        logic [9:0] lvl;
        logic       anim;
        logic       last;
    } led_write_t;

    // ramp state and settings mirrored from the block, plus the writes still owed
    class led_frame_board;
        logic [15:0]        interval_ms;
        logic               flip_down;
        logic signed [11:0] level_cur;
        logic signed [11:0] level_from;
        logic signed [11:0] level_to;
        logic [31:0]        time_from;
        logic [31:0]        time_to;
        logic [31:0]        time_last;
        led_write_t         writes_due[$];
        int                 mismatches;

        function new();
            interval_ms = UPDATE_INTERVAL_RESET;
            flip_down   = 1'b0;
            level_cur   = '0;
            level_from  = '0;
            level_to    = '0;
            time_from   = '0;
            time_to     = '0;
            time_last   = '0;
            mismatches  = 0;
        endfunction

        function void set_register(logic [0:0] idx, logic [15:0] value);
            if (idx == REG_UPDATE_INTERVAL) begin
                interval_ms = value;
            end else begin
                flip_down = value[0];
            end
        endfunction

        // note an accepted beat; returns 1 when it set up a ramp or redrew the strip
        function bit take_beat(logic [2:0] op, logic [31:0] now, logic [15:0] dur_raw,
                               logic [9:0] target);
            logic [31:0] dur32;
            logic [31:0] moved_end;
            logic [31:0] t_clamped;
            logic [31:0] span_num;
            logic [31:0] span_den;
            longint      num;
            longint      den;
            longint      lvl_a;
            longint      lvl_b;
            longint      lvl;
            longint      sat_acc;
            longint      prod;
            int          sat;
            int          bri;
            int          side;
            int          pos;
            int          n;
            int          total;
            bit          up;
            led_write_t  w;

            dur32 = {{16{dur_raw[15]}}, dur_raw};
            case (op)
                OP_TURN_ON: begin
                    level_from = level_cur + 12'sd1;
                    level_to   = 12'sd1023;
                    level_cur  = level_cur + 12'sd1;
                    time_from  = now;
                    time_to    = now + dur32;
                    return 1'b1;
                end
                OP_TURN_OFF: begin
                    level_from = level_cur - 12'sd1;
                    level_to   = 12'sd0;
                    level_cur  = level_cur - 12'sd1;
                    time_from  = now;
                    time_to    = now + dur32;
                    return 1'b1;
                end
                OP_SET_LEVEL: begin
                    level_from = level_cur;
                    level_to   = $signed({2'b00, target});
                    time_from  = now;
                    time_to    = now + dur32;
                    return 1'b1;
                end
                OP_CHANGE_TIME: begin
                    moved_end = time_to + dur32;
                    if (moved_end > now) time_to = moved_end;
                    return 1'b1;
                end
                OP_TICK: ;
                default: return 1'b0;
            endcase

            // interval must be strictly exceeded, wrapping difference
            if (now - time_last <= {16'b0, interval_ms}) return 1'b0;

            if (now < time_from) begin
                t_clamped = time_from;
            end else if (now > time_to) begin
                t_clamped = time_to;
            end else begin
                t_clamped = now;
            end
            span_num = t_clamped - time_from;
            span_den = time_to - time_from;
            num   = $signed(span_num);
            den   = $signed(span_den);
            lvl_a = level_from;
            lvl_b = level_to;
            // zero-length ramp jumps to its end level; division truncates toward zero
            if (den == 0) begin
                lvl = lvl_b;
            end else begin
                lvl = num * (lvl_b - lvl_a) / den + lvl_a;
            end
            if (lvl < 0) lvl = 0;
            if (lvl > 1023) lvl = 1023;
            level_cur = lvl[11:0];
            time_last = now;

            // saturation falls from 170 as the level rises, 12 * level capped at 5115
            sat_acc = 12 * lvl;
            if (sat_acc > 5115) sat_acc = 5115;
            sat = 170 - int'((sat_acc * 16 + 1022) / 1023);

            total = SIDES * LEDS_PER_SIDE;
            if (total > MAX_WRITES) total = MAX_WRITES;
            n = 0;
            for (pos = 0; pos < LEDS_PER_SIDE && n < total; pos++) begin
                // brightness grows with 7 * (pos + 1) * level
                prod = 7 * longint'(pos + 1) * lvl;
                bri  = (prod >= 5115) ? 255 : int'(prod * 255 / 5115);
                for (side = 0; side < SIDES && n < total; side++) begin
                    up = flip_down ? !side[0] : side[0];
                    w.led_idx = 6'(side * LEDS_PER_SIDE + (up ? pos : LEDS_PER_SIDE - 1 - pos));
                    w.sat     = 8'(sat);
                    w.bri     = 8'(bri);
                    w.lvl     = level_cur[9:0];
                    w.anim    = (level_cur != level_to);
                    w.last    = (n == total - 1);
                    writes_due.push_back(w);
                    n++;
                end
            end
            return 1'b1;
        endfunction

        function void check_write(logic [39:0] data, logic last);
            led_write_t want;
            led_write_t got;

            got = '{led_idx: data[5:0], sat: data[13:6], bri: data[21:14],
                    lvl: data[31:22], anim: data[32], last: last};
            if (writes_due.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT) begin
                    $display("%0t: led write with none pending: idx %0d sat %0d bri %0d lvl %0d",
                             $time, got.led_idx, got.sat, got.bri, got.lvl);
                end
                return;
            end
            want = writes_due.pop_front();
            if (got.led_idx !== want.led_idx || got.sat !== want.sat || got.bri !== want.bri ||
                    got.lvl !== want.lvl || got.anim !== want.anim || got.last !== want.last) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT) begin
                    $display("%0t: led write mismatch", $time);
                    $display("  expected idx %0d sat %0d bri %0d lvl %0d anim %0b last %0b",
                             want.led_idx, want.sat, want.bri, want.lvl, want.anim, want.last);
                    $display("  actual   idx %0d sat %0d bri %0d lvl %0d anim %0b last %0b",
                             got.led_idx, got.sat, got.bri, got.lvl, got.anim, got.last);
                end
            end
        endfunction
    endclass

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [0:0]  cfg_index = REG_UPDATE_INTERVAL;
    logic [15:0] cfg_wdata = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata   = '0;   // now_ms[31:0], duration[47:32], target_level[57:48]
    logic [2:0]  s_tuser   = OP_TICK;   // operation[2:0]
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [39:0] m_tdata;   // led_index[5:0], saturation[13:6], brightness[21:14],
                            // current_level[31:22], animating[32]
    logic        m_tlast;   // last_write

    bit          no_gaps       = 1'b0;    // both sides run flat out while set
    logic [31:0] clock_ms      = '0;      // millisecond time handed to the block
    int          counted_beats = 0;       // beats that set up a ramp or redrew the strip

    led_frame_board frames = new();

    always #5ns aclk = ~aclk;

    led_fade_ramp_profile #(
        .SIDES         (SIDES),
        .LEDS_PER_SIDE (LEDS_PER_SIDE)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    // receiver: check each accepted write, then pick the ready for the next edge
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) frames.check_write(m_tdata, m_tlast);
        m_tready <= no_gaps || ($urandom_range(99) >= GAP_PCT);
    end

    // present one beat and hold it until taken; valid stays high for a back-to-back beat
    task automatic send_beat(input logic [2:0] op, input logic [31:0] now,
                             input logic [15:0] dur, input logic [9:0] target);
        while (!no_gaps && $urandom_range(99) < GAP_PCT) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {6'b0, target, dur, now};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (frames.take_beat(op, now, dur, target)) counted_beats++;
    endtask

    // drop valid and wait for every owed write, then let the block settle
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (frames.writes_due.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // both registers in back-to-back cycles; upper bits of the orientation word are junk
    task automatic write_settings(input logic [15:0] interval, input logic down);
        logic [15:0] junk;
        junk = 16'($urandom);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_UPDATE_INTERVAL;
        cfg_wdata <= interval;
        @(posedge aclk);
        cfg_index <= REG_ORIENTATION_DOWN;
        cfg_wdata <= {junk[15:1], down};
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        frames.set_register(REG_UPDATE_INTERVAL, interval);
        frames.set_register(REG_ORIENTATION_DOWN, {junk[15:1], down});
    endtask

    // mostly a ramp set-up followed by a burst of ticks, some noise beats in between
    task automatic run_phase(input int goal);
        int          start_count;
        int          bursts;
        int          advance;
        logic [2:0]  op;
        logic [15:0] dur;
        bit          paused;

        start_count = counted_beats;
        paused      = 1'b0;
        while (counted_beats - start_count < goal) begin
            if (!paused && counted_beats - start_count >= goal / 2) begin
                // sender holds off until the strip has caught up
                wait_idle();
                paused = 1'b1;
            end
            if ($urandom_range(99) < 15) begin
                send_beat(3'($urandom), $urandom, 16'($urandom), 10'($urandom));
            end else begin
                op  = 3'($urandom_range(OP_TURN_ON, OP_CHANGE_TIME));
                dur = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3000));
                send_beat(op, clock_ms, dur, 10'($urandom));
                bursts = $urandom_range(1, 5);
                repeat (bursts) begin
                    // now and then a tick that comes too early
                    if ($urandom_range(9) == 0) begin
                        advance = $urandom_range(0, frames.interval_ms);
                    end else begin
                        advance = frames.interval_ms + 1 + $urandom_range(0, 400);
                    end
                    clock_ms += 32'(advance);
                    send_beat(OP_TICK, clock_ms, 16'($urandom), 10'($urandom));
                end
            end
        end
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed part, reset settings: 20 ms interval, normal orientation
        send_beat(OP_TICK, 32'd0, 16'd0, 10'd0);                  // not due yet
        send_beat(OP_TICK, 32'd21, 16'd0, 10'd0);                 // zero-length ramp at level 0
        send_beat(OP_TURN_ON, 32'd30, 16'd100, 10'd0);
        send_beat(OP_TICK, 32'd80, 16'd0, 10'd0);                 // halfway up
        send_beat(OP_CHANGE_TIME, 32'd90, 16'sh7FFF, 10'd0);      // stretch end time
        send_beat(OP_CHANGE_TIME, 32'd100, 16'sh8000, 10'd0);     // pull it back, still ahead
        send_beat(OP_CHANGE_TIME, 32'd200, -16'sd100, 10'd0);     // would fall behind, ignored
        send_beat(OP_TICK, 32'd200, 16'd0, 10'd0);                // past end, full level
        send_beat(OP_TICK, 32'd210, 16'd0, 10'd0);                // too soon
        send_beat(OP_TURN_ON, 32'd300, 16'd0, 10'd0);             // start level above the top
        send_beat(OP_TICK, 32'd400, 16'd0, 10'd0);
        send_beat(OP_TURN_OFF, 32'd500, 16'sh8000, 10'd0);       // negative length ramp
        send_beat(OP_TICK, 32'd600, 16'd0, 10'd0);                // overshoots, clamped high
        send_beat(OP_SET_LEVEL, 32'd700, 16'sh7FFF, 10'd0);
        send_beat(OP_TICK, 32'd17083, 16'd0, 10'd0);              // mid ramp
        send_beat(OP_SET_LEVEL, 32'hFFFF_FF00, 16'd1000, 10'd1023);  // end time wraps
        send_beat(OP_TICK, 32'hFFFF_FFFF, 16'hFFFF, 10'd1023);
        send_beat(OP_TICK, 32'h0000_0100, 16'd0, 10'd0);          // clock wrapped, before start
        send_beat(OP_SET_LEVEL, 32'h0000_0310, 16'd0, 10'd0);
        send_beat(OP_TICK, 32'h0000_0340, 16'd0, 10'd0);          // level back to 0
        send_beat(OP_TURN_OFF, 32'h0000_0350, 16'd200, 10'd0);    // start level goes negative
        send_beat(OP_TICK, 32'h0000_0380, 16'd0, 10'd0);          // clamped low
        send_beat(OP_SPARE_FIRST, $urandom, 16'($urandom), 10'($urandom));
        send_beat(OP_SPARE_FIRST + 3'd1, $urandom, 16'($urandom), 10'($urandom));
        send_beat(OP_SPARE_LAST, $urandom, 16'($urandom), 10'($urandom));
        clock_ms = 32'h0000_0400;
        wait_idle();

        // every tick that moves time is due, flipped orientation
        write_settings(16'd0, 1'b1);
        run_phase(80);
        wait_idle();

        // longest interval, ramps always finish between recomputations
        write_settings(16'hFFFF, 1'b0);
        run_phase(55);
        wait_idle();

        // no idling on either side for this whole phase
        no_gaps = 1'b1;
        write_settings(16'($urandom_range(1, 100)), 1'b1);
        run_phase(100);
        wait_idle();
        no_gaps = 1'b0;

        write_settings(UPDATE_INTERVAL_RESET, 1'b0);
        run_phase(90);
        wait_idle();

        if (frames.mismatches == 0 && frames.writes_due.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // watchdog, far beyond the slowest correct run
    initial begin
        #5ms;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

>>> led_fade_ramp_profile.f
sv/lfrp_pkg.sv
sv/lfrp_div.sv
sv/lfrp_ctrl.sv
sv/lfrp_dp.sv
sv/led_fade_ramp_profile.sv
bench/led_fade_ramp_profile_tb.sv
